// ===== sv/idt_pkg.sv =====
// shared types and constants of the interpreter data tape
package idt_pkg;

    // default sizes of the tape
    localparam int CELL_BITS_DEF  = 8;
    localparam int TAPE_DEPTH_DEF = 4096;

    // fixed port widths
    localparam int CMD_W      = 3;
    localparam int BYTE_W     = 8;
    localparam int VAL_W      = 8;
    localparam int POS_W      = 12;
    localparam int LEN_W      = 13;
    localparam int EOF_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // register reset values
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(4096);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TAPE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EOF_MODE    = 2'd2;

    // edge behavior
    localparam logic EDGE_WRAP = 1'b0;
    localparam logic EDGE_STOP = 1'b1;

    // end of input behavior
    localparam logic [EOF_W-1:0] EOF_ZERO = 2'd0;
    localparam logic [EOF_W-1:0] EOF_ONES = 2'd1;
    localparam logic [EOF_W-1:0] EOF_KEEP = 2'd2;

    // tape commands
    typedef enum logic [CMD_W-1:0] {
        CMD_INC   = 3'd0,
        CMD_DEC   = 3'd1,
        CMD_RIGHT = 3'd2,
        CMD_LEFT  = 3'd3,
        CMD_READ  = 3'd4,
        CMD_WRITE = 3'd5
    } cmd_t;

endpackage

// ===== sv/interpreter_data_tape.sv =====
// top level of the interpreter data tape: head control, cell update and tape ram
// A taken command passes the cell stage, then the result registers strobe done.
// Throughput: one command per cycle while busy is low; a command reads its cell
// from the tape ram and a same-cell write of the previous command is forwarded
// around the ram. Reset: registers return to defaults, head to zero, then a
// clearing pass zeroes the whole tape with busy high. The receiver cannot stall.
module interpreter_data_tape #(
    parameter int CELL_BITS  = idt_pkg::CELL_BITS_DEF,
    parameter int TAPE_DEPTH = idt_pkg::TAPE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [idt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [idt_pkg::CFG_DATA_W-1:0] cfg_data,
    // command beat
    input  logic                          start,
    output logic                          busy,
    input  logic [idt_pkg::CMD_W-1:0]     command,
    input  logic [idt_pkg::BYTE_W-1:0]    in_byte,
    input  logic                          in_eof,
    // result beat
    output logic                          done,
    output logic [idt_pkg::VAL_W-1:0]     cell_value,
    output logic                          cell_zero,
    output logic                          range_error,
    output logic [idt_pkg::POS_W-1:0]     head_position,
    output logic                          output_valid
);

    import idt_pkg::*;

    localparam int HEAD_BITS = $clog2(TAPE_DEPTH);
    localparam int LCW = (HEAD_BITS + 1 > LEN_W) ? HEAD_BITS + 1 : LEN_W;

    // configuration registers
    logic [LEN_W-1:0] tape_length_reg;
    logic             edge_mode_reg;
    logic [EOF_W-1:0] eof_mode_reg;

    // clearing pass
    logic                 clearing_reg;
    logic [HEAD_BITS-1:0] clr_addr_reg;

    // head and first stage
    logic [HEAD_BITS-1:0] head_reg;
    logic [HEAD_BITS-1:0] head_next;
    logic                 err_next;
    logic [HEAD_BITS-1:0] last_idx;
    logic [LCW-1:0]       len_ext;
    logic                 accept;

    // cell stage
    logic                 b_valid_reg;
    logic [CMD_W-1:0]     b_cmd_reg;
    logic [HEAD_BITS-1:0] b_head_reg;
    logic [BYTE_W-1:0]    b_byte_reg;
    logic                 b_eof_reg;
    logic                 b_err_reg;
    logic                 fwd_hit_reg;
    logic [CELL_BITS-1:0] fwd_data_reg;
    logic [CELL_BITS-1:0] ram_rdata;
    logic [CELL_BITS-1:0] cell_old;
    logic [CELL_BITS-1:0] cell_new;

    // ram ports
    logic                 ram_we;
    logic [HEAD_BITS-1:0] ram_waddr;
    logic [CELL_BITS-1:0] ram_wdata;

    // result registers
    logic                 done_reg;
    logic [VAL_W-1:0]     cell_value_reg;
    logic                 cell_zero_reg;
    logic                 range_error_reg;
    logic [POS_W-1:0]     head_position_reg;
    logic                 output_valid_reg;
    logic [HEAD_BITS+POS_W-1:0] head_pos_ext;

    assign busy   = clearing_reg;
    assign accept = start && !clearing_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tape_length_reg <= LEN_RESET;
            edge_mode_reg   <= EDGE_WRAP;
            eof_mode_reg    <= EOF_ZERO;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TAPE_LENGTH: tape_length_reg <= cfg_data[LEN_W-1:0];
                REG_EDGE_MODE:   edge_mode_reg   <= cfg_data[0];
                REG_EOF_MODE:    eof_mode_reg    <= cfg_data[EOF_W-1:0];
                default:         ;
            endcase
        end
    end

    // last usable index, length zero acts as one cell, clamp to the tape
    always_comb
    begin
        len_ext = LCW'(tape_length_reg);
        if (len_ext == '0)
        begin
            last_idx = '0;
        end
        else if (len_ext > LCW'(TAPE_DEPTH))
        begin
            last_idx = HEAD_BITS'(TAPE_DEPTH - 1);
        end
        else
        begin
            last_idx = HEAD_BITS'(len_ext - LCW'(1));
        end
    end

    // head movement and edge handling
    always_comb
    begin
        head_next = head_reg;
        err_next  = 1'b0;
        case (command)
            CMD_RIGHT:
            begin
                if (head_reg >= last_idx)
                begin
                    if (edge_mode_reg == EDGE_WRAP)
                    begin
                        head_next = '0;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                else
                begin
                    head_next = head_reg + HEAD_BITS'(1);
                end
            end
            CMD_LEFT:
            begin
                if (head_reg == '0)
                begin
                    if (edge_mode_reg == EDGE_WRAP)
                    begin
                        head_next = last_idx;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                else
                begin
                    head_next = head_reg - HEAD_BITS'(1);
                end
            end
            default: ;
        endcase
    end

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + HEAD_BITS'(1);
            if (clr_addr_reg == HEAD_BITS'(TAPE_DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // head register and first stage, with same-cell forward from the cell stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            b_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= accept;
            if (accept)
            begin
                head_reg    <= head_next;
                fwd_hit_reg <= b_valid_reg && (b_head_reg == head_next);
            end
        end
    end

    // first stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_cmd_reg    <= command;
            b_head_reg   <= head_next;
            b_byte_reg   <= in_byte;
            b_eof_reg    <= in_eof;
            b_err_reg    <= err_next;
            fwd_data_reg <= cell_new;
        end
    end

    // cell update
    always_comb
    begin
        cell_old = fwd_hit_reg ? fwd_data_reg : ram_rdata;
        cell_new = cell_old;
        case (b_cmd_reg)
            CMD_INC: cell_new = cell_old + CELL_BITS'(1);
            CMD_DEC: cell_new = cell_old - CELL_BITS'(1);
            CMD_READ:
            begin
                if (!b_eof_reg)
                begin
                    cell_new = CELL_BITS'(b_byte_reg);
                end
                else if (eof_mode_reg == EOF_ZERO)
                begin
                    cell_new = '0;
                end
                else if (eof_mode_reg == EOF_ONES)
                begin
                    cell_new = '1;
                end
            end
            default: ;
        endcase
    end

    // ram write port shared by the clearing pass and the cell stage
    assign ram_we    = clearing_reg || b_valid_reg;
    assign ram_waddr = clearing_reg ? clr_addr_reg : b_head_reg;
    assign ram_wdata = clearing_reg ? '0 : cell_new;

    idt_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (TAPE_DEPTH)
    ) u_tape (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    assign head_pos_ext = {{POS_W{1'b0}}, b_head_reg};

    // result beat strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= b_valid_reg;
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (b_valid_reg)
        begin
            cell_value_reg    <= cell_new[VAL_W-1:0];
            cell_zero_reg     <= (cell_new == '0);
            range_error_reg   <= b_err_reg;
            head_position_reg <= head_pos_ext[POS_W-1:0];
            output_valid_reg  <= (b_cmd_reg == CMD_WRITE);
        end
    end

    assign done          = done_reg;
    assign cell_value    = cell_value_reg;
    assign cell_zero     = cell_zero_reg;
    assign range_error   = range_error_reg;
    assign head_position = head_position_reg;
    assign output_valid  = output_valid_reg;

endmodule

// ===== sv/idt_ram.sv =====
// generic single-port-write ram with registered read, old data on collision
module idt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
